// ===== sv/hangul_two_set_syllable_composer_defines.svh =====
// Assertion macros for the Hangul two-set syllable composer.
`ifndef HANGUL_TWO_SET_SYLLABLE_COMPOSER_DEFINES_SVH
`define HANGUL_TWO_SET_SYLLABLE_COMPOSER_DEFINES_SVH

`ifndef SYNTH

// Check that a property holds at every rising clock edge outside reset.
`define HTSC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("hangul composer: property violated");

// Check that a condition never occurs outside reset.
`define HTSC_ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("hangul composer: forbidden condition seen");

`else

`define HTSC_ASSERT(name, clk, rstn, prop)
`define HTSC_ASSERT_NEVER(name, clk, rstn, expr)

`endif

`endif

// ===== sv/htsc_pkg.sv =====
// Types, constants and jamo tables for the Hangul two-set syllable composer.
package htsc_pkg;

  // Johab fill code: all three slots empty
  localparam logic [15:0] FILL_CODE = 16'h8441;

  // Slot masks that keep everything but one slot
  localparam logic [15:0] MASK_INITIAL = 16'h83FF;
  localparam logic [15:0] MASK_MEDIAL  = 16'hFC1F;
  localparam logic [15:0] MASK_FINAL   = 16'hFFE0;

  // Key class bits: vowels have 0b01 in bits 6:5
  localparam logic [7:0] KEY_CLASS_MASK = 8'h60;
  localparam logic [7:0] KEY_CLASS_VOWEL = 8'h20;

  // Action codes
  localparam logic ACT_KEY   = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Syllable phase
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_INIT  = 3'd1,
    PH_MED   = 3'd2,
    PH_DMED  = 3'd3,
    PH_FIN   = 3'd4,
    PH_DFIN  = 3'd5
  } phase_e;

  // What one beat does to the syllable
  typedef enum logic [3:0] {
    STEP_HOLD,
    STEP_FLUSH,
    STEP_START,
    STEP_PUSH_MED,
    STEP_PUSH_DMED,
    STEP_PUSH_FIN,
    STEP_PUSH_DFIN,
    STEP_MOVE_FIN,
    STEP_RESTART
  } step_e;

  // One result beat
  typedef struct packed {
    logic        commit_valid;
    logic [15:0] commit_code;
    logic        compose_active;
    logic [15:0] compose_code;
  } res_t;

  // Compound medial for a vowel pair, zero when the pair does not combine
  function automatic logic [7:0] med_pair(input logic [7:0] first_key,
                                          input logic [7:0] second_key);
    logic [7:0] comp;
    case ({first_key, second_key})
      16'hADA3: comp = 8'hAE;
      16'hADA4: comp = 8'hAF;
      16'hADBD: comp = 8'hB2;
      16'hB4A7: comp = 8'hB5;
      16'hB4AA: comp = 8'hB6;
      16'hB4BD: comp = 8'hB7;
      16'hBBBD: comp = 8'hBC;
      default:  comp = 8'h00;
    endcase
    return comp;
  endfunction

  // Compound final for a consonant pair, zero when the pair does not combine
  function automatic logic [7:0] fin_pair(input logic [7:0] first_key,
                                          input logic [7:0] second_key);
    logic [7:0] comp;
    case ({first_key, second_key})
      16'h828B: comp = 8'hC4;
      16'h848E: comp = 8'hC6;
      16'h8494: comp = 8'hC7;
      16'h8782: comp = 8'hCA;
      16'h8788: comp = 8'hCB;
      16'h8789: comp = 8'hCC;
      16'h878B: comp = 8'hCD;
      16'h8792: comp = 8'hCE;
      16'h8793: comp = 8'hCF;
      16'h8794: comp = 8'hD0;
      16'h898B: comp = 8'hD4;
      default:  comp = 8'h00;
    endcase
    return comp;
  endfunction

  // Final code for an initial consonant key, zero when it cannot close a syllable
  function automatic logic [7:0] init_to_fin(input logic [7:0] key);
    logic [7:0] fin;
    case (key)
      8'h82:   fin = 8'hC2;
      8'h83:   fin = 8'hC3;
      8'h84:   fin = 8'hC5;
      8'h85:   fin = 8'hC8;
      8'h87:   fin = 8'hC9;
      8'h88:   fin = 8'hD1;
      8'h89:   fin = 8'hD3;
      8'h8B:   fin = 8'hD5;
      8'h8C:   fin = 8'hD6;
      8'h8D:   fin = 8'hD7;
      8'h8E:   fin = 8'hD8;
      8'h90:   fin = 8'hD9;
      8'h91:   fin = 8'hDA;
      8'h92:   fin = 8'hDB;
      8'h93:   fin = 8'hDC;
      8'h94:   fin = 8'hDD;
      default: fin = 8'h00;
    endcase
    return fin;
  endfunction

  // Place a consonant key in the initial slot
  function automatic logic [15:0] put_initial(input logic [15:0] code,
                                              input logic [7:0] key);
    return (code & MASK_INITIAL) | {1'b0, key[4:0], 10'b0};
  endfunction

  // Place a vowel code in the medial slot
  function automatic logic [15:0] put_medial(input logic [15:0] code,
                                             input logic [7:0] key);
    return (code & MASK_MEDIAL) | {6'b0, key[4:0], 5'b0};
  endfunction

  // Place a final code in the final slot
  function automatic logic [15:0] put_final(input logic [15:0] code,
                                            input logic [7:0] fin);
    return (code & MASK_FINAL) | {11'b0, fin[4:0]};
  endfunction

endpackage

// ===== sv/hangul_two_set_syllable_composer.sv =====
// Top level of the Hangul two-set syllable composer.
// Input channel: one beat per key stroke, carrying action_i (0 = jamo key,
// 1 = flush) and jamo_key_i. A beat is taken on a rising edge with
// in_valid_i high and in_stall_o low.
// Output channel: exactly one result beat per input beat, in order, with
// commit_valid_o/commit_code_o for a finished syllable and
// compose_active_o/compose_code_o for the syllable still being built.
// A result beat is taken on a rising edge with out_valid_o high and
// out_stall_i low.
// Throughput: one beat is taken every cycle while in_stall_o is low; the
// result is registered in the output stage, and the phase and syllable code
// registers close their update loop through combinational logic alone.
// Stall: a two-entry output stage (result register plus skid register) keeps
// taking beats while a result waits. When both entries are full, in_stall_o
// rises and stays high until the receiver takes a result.
// Reset: rst_ni clears the phase to start and empties the output stage; no
// syllable is in progress and no result is pending.
`include "hangul_two_set_syllable_composer_defines.svh"

module hangul_two_set_syllable_composer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  jamo_key_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        commit_valid_o,
  output logic [15:0] commit_code_o,
  output logic        compose_active_o,
  output logic [15:0] compose_code_o
);

  // Syllable state
  htsc_pkg::phase_e phase_q, phase_d;
  logic [15:0]      cur_code_q, cur_code_d;
  logic [15:0]      prev_code_q, prev_code_d;
  logic [7:0]       last_key_q, last_key_d;

  // Output stage
  logic             out_valid_q;
  logic             skid_valid_q;
  htsc_pkg::res_t   out_q;
  htsc_pkg::res_t   skid_q;
  htsc_pkg::res_t   res_d;

  // Decode
  htsc_pkg::step_e  step;
  logic             in_acc;
  logic             out_take;
  logic             out_free;
  logic             active;
  logic             key_ok;
  logic             vowel;
  logic             can_final;
  logic [7:0]       med_comp;
  logic [7:0]       fin_comp;
  logic [15:0]      start_code;
  htsc_pkg::phase_e start_phase;
  logic [15:0]      moved_init;

  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || out_take;

  // Classify the key
  assign active    = (phase_q != htsc_pkg::PH_START);
  assign key_ok    = jamo_key_i inside {[8'h82:8'h94], [8'hA3:8'hBD]};
  assign vowel     = (jamo_key_i & htsc_pkg::KEY_CLASS_MASK) == htsc_pkg::KEY_CLASS_VOWEL;
  assign can_final = !vowel && !(jamo_key_i inside {8'h86, 8'h8A, 8'h8F});
  assign med_comp  = htsc_pkg::med_pair(last_key_q, jamo_key_i);
  assign fin_comp  = htsc_pkg::fin_pair(last_key_q, jamo_key_i);

  // Fresh syllable from one key
  assign start_code  = vowel ? htsc_pkg::put_medial(htsc_pkg::FILL_CODE, jamo_key_i)
                             : htsc_pkg::put_initial(htsc_pkg::FILL_CODE, jamo_key_i);
  assign start_phase = vowel ? htsc_pkg::PH_MED : htsc_pkg::PH_INIT;
  // Last final moved to the front of a new syllable
  assign moved_init  = htsc_pkg::put_initial(htsc_pkg::FILL_CODE, last_key_q);

  // Choose the step for this beat
  always_comb begin
    step = htsc_pkg::STEP_HOLD;
    if (action_i == htsc_pkg::ACT_FLUSH) begin
      step = htsc_pkg::STEP_FLUSH;
    end else if (!key_ok) begin
      step = htsc_pkg::STEP_HOLD;
    end else if (!active) begin
      step = htsc_pkg::STEP_START;
    end else begin
      case (phase_q)
        htsc_pkg::PH_INIT: begin
          step = vowel ? htsc_pkg::STEP_PUSH_MED : htsc_pkg::STEP_RESTART;
        end
        htsc_pkg::PH_MED: begin
          if (can_final) step = htsc_pkg::STEP_PUSH_FIN;
          else if (med_comp != 8'h00) step = htsc_pkg::STEP_PUSH_DMED;
          else step = htsc_pkg::STEP_RESTART;
        end
        htsc_pkg::PH_DMED: begin
          step = can_final ? htsc_pkg::STEP_PUSH_FIN : htsc_pkg::STEP_RESTART;
        end
        htsc_pkg::PH_FIN: begin
          if (!vowel && fin_comp != 8'h00) step = htsc_pkg::STEP_PUSH_DFIN;
          else if (vowel) step = htsc_pkg::STEP_MOVE_FIN;
          else step = htsc_pkg::STEP_RESTART;
        end
        htsc_pkg::PH_DFIN: begin
          step = vowel ? htsc_pkg::STEP_MOVE_FIN : htsc_pkg::STEP_RESTART;
        end
        default: begin
          step = htsc_pkg::STEP_START;
        end
      endcase
    end
  end

  // Apply the step to the syllable state and build the result
  always_comb begin
    phase_d                = phase_q;
    cur_code_d             = cur_code_q;
    prev_code_d            = prev_code_q;
    last_key_d             = last_key_q;
    res_d.commit_valid     = 1'b0;
    res_d.commit_code      = 16'h0000;
    case (step)
      htsc_pkg::STEP_FLUSH: begin
        res_d.commit_valid = active;
        res_d.commit_code  = active ? cur_code_q : 16'h0000;
        phase_d            = htsc_pkg::PH_START;
      end
      htsc_pkg::STEP_START: begin
        phase_d    = start_phase;
        cur_code_d = start_code;
        last_key_d = jamo_key_i;
      end
      htsc_pkg::STEP_PUSH_MED: begin
        phase_d     = htsc_pkg::PH_MED;
        prev_code_d = cur_code_q;
        cur_code_d  = htsc_pkg::put_medial(cur_code_q, jamo_key_i);
        last_key_d  = jamo_key_i;
      end
      htsc_pkg::STEP_PUSH_DMED: begin
        phase_d     = htsc_pkg::PH_DMED;
        prev_code_d = cur_code_q;
        cur_code_d  = htsc_pkg::put_medial(cur_code_q, med_comp);
        last_key_d  = jamo_key_i;
      end
      htsc_pkg::STEP_PUSH_FIN: begin
        phase_d     = htsc_pkg::PH_FIN;
        prev_code_d = cur_code_q;
        cur_code_d  = htsc_pkg::put_final(cur_code_q, htsc_pkg::init_to_fin(jamo_key_i));
        last_key_d  = jamo_key_i;
      end
      htsc_pkg::STEP_PUSH_DFIN: begin
        phase_d     = htsc_pkg::PH_DFIN;
        prev_code_d = cur_code_q;
        cur_code_d  = htsc_pkg::put_final(cur_code_q, fin_comp);
        last_key_d  = jamo_key_i;
      end
      htsc_pkg::STEP_MOVE_FIN: begin
        // commit the syllable without its last final, reopen with that final
        res_d.commit_valid = 1'b1;
        res_d.commit_code  = prev_code_q;
        phase_d            = htsc_pkg::PH_MED;
        prev_code_d        = moved_init;
        cur_code_d         = htsc_pkg::put_medial(moved_init, jamo_key_i);
        last_key_d         = jamo_key_i;
      end
      htsc_pkg::STEP_RESTART: begin
        res_d.commit_valid = 1'b1;
        res_d.commit_code  = cur_code_q;
        phase_d            = start_phase;
        cur_code_d         = start_code;
        last_key_d         = jamo_key_i;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
    res_d.compose_active = (phase_d != htsc_pkg::PH_START);
    res_d.compose_code   = (phase_d != htsc_pkg::PH_START) ? cur_code_d
                                                           : htsc_pkg::FILL_CODE;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= htsc_pkg::PH_START;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_acc) phase_q <= phase_d;
      if (out_free) begin
        out_valid_q  <= skid_valid_q || in_acc;
        skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_code_q  <= cur_code_d;
      prev_code_q <= prev_code_d;
      last_key_q  <= last_key_d;
    end
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  // Drive ports
  assign in_stall_o       = skid_valid_q;
  assign out_valid_o      = out_valid_q;
  assign commit_valid_o   = out_q.commit_valid;
  assign commit_code_o    = out_q.commit_code;
  assign compose_active_o = out_q.compose_active;
  assign compose_code_o   = out_q.compose_code;

  // Assertions
  `HTSC_ASSERT_NEVER(a_skid_needs_out, clk_i, rst_ni, skid_valid_q && !out_valid_q)
  `HTSC_ASSERT_NEVER(a_no_commit_zero, clk_i, rst_ni, out_valid_q && !out_q.commit_valid && out_q.commit_code != 16'h0000)
  `HTSC_ASSERT_NEVER(a_idle_fill, clk_i, rst_ni, out_valid_q && !out_q.compose_active && out_q.compose_code != htsc_pkg::FILL_CODE)
  `HTSC_ASSERT(a_flush_to_start, clk_i, rst_ni, (in_acc && action_i == htsc_pkg::ACT_FLUSH) |=> (phase_q == htsc_pkg::PH_START))

endmodule
